### hdl/dpg_pkg.sv
// Shared types, constants and helpers for the dirty-pixel gamma presenter.
`timescale 1ns / 1ps
`default_nettype none

package dpg_pkg;

    localparam int MAX_WIDTH   = 128;
    localparam int MAX_HEIGHT  = 64;
    localparam int X_W         = 7;
    localparam int Y_W         = 6;
    localparam int PIX_W       = 16;
    localparam int LEVEL_W     = 8;
    localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int STORE_AW    = $clog2(STORE_DEPTH);
    localparam int GAMMA_DEPTH = 256;
    localparam int GAMMA_AW    = $clog2(GAMMA_DEPTH);

    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 40;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 8;

    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);

    localparam logic [1:0] MODE_FRAME_START = 2'd0;
    localparam logic [1:0] MODE_PIXEL       = 2'd1;
    localparam logic [1:0] MODE_FRAME_END   = 2'd2;
    localparam logic [1:0] MODE_GAMMA_WRITE = 2'd3;

    localparam logic KIND_DRAW = 1'b0;
    localparam logic KIND_FLIP = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_BUFFER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 2'd2;

    localparam logic [7:0] FRAME_WIDTH_RST  = 8'd128;
    localparam logic [6:0] FRAME_HEIGHT_RST = 7'd64;

    typedef struct packed {
        logic               kind;
        logic [X_W-1:0]     x;
        logic [Y_W-1:0]     y;
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } dpg_out_t;

    function automatic logic [STORE_AW-1:0] store_addr(input logic [X_W-1:0] x,
                                                       input logic [Y_W-1:0] y);
        return STORE_AW'(int'(y) * MAX_WIDTH + int'(x));
    endfunction

    function automatic logic [GAMMA_AW-1:0] widen5(input logic [4:0] v);
        return {v, v[4:2]};
    endfunction

    function automatic logic [GAMMA_AW-1:0] widen6(input logic [5:0] v);
        return {v, v[5:4]};
    endfunction

endpackage

`default_nettype wire

### hdl/dirty_pixel_gamma_presenter.sv
// Top level of the dirty-pixel gamma presenter: decode, frame store and pipeline.
//
// Input requests arrive on s_*; s_tuser carries the mode (frame start, pixel,
// frame end, gamma write). Pixels inside the frame are compared with a
// previous-frame store and emitted on m_* only if changed or the frame is
// forced; drawn colors go through the gamma table. A frame end emits a flip
// request (m_tuser = 1, data zero) when double buffering is on.
// Configuration is written through cfg_wr_en / cfg_index / cfg_wdata; the user
// must do so only while idle, which the block itself does not enforce.
// Throughput: one request per cycle while s_tready is high. A result passes
// through stage 1 (store read and compare) and stage 2 (gamma read) into the
// output queue, shows on m_* once queued, and leaves the queue on m_tready.
// The store is read once per pixel and written only when the pixel is drawn;
// a write still in flight to the same entry is forwarded to the compare.
// Reset: aresetn clears control state and starts a clearing pass over the
// 8192-entry previous-frame store, one entry a cycle; s_tready stays low until
// the pass ends. The gamma table has no reset and must be loaded first.
// Stall: results wait in a four-entry queue; s_tready drops when the queue
// count plus the requests in the two pipeline stages reaches four.
`timescale 1ns / 1ps
`default_nettype none

module dirty_pixel_gamma_presenter (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [dpg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dpg_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // force_req, pixel_x, pixel_y, pixel_value, table_index, table_value
    input  wire logic [dpg_pkg::S_TDATA_W-1:0]     s_tdata,
    // mode
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // out_x, out_y, red, green, blue
    output logic      [dpg_pkg::M_TDATA_W-1:0]     m_tdata,
    // kind
    output logic                                   m_tuser
);

    logic                              double_buffer_reg;
    logic [7:0]                        frame_width_reg;
    logic [6:0]                        frame_height_reg;
    logic                              repaint_pending_reg;
    logic                              frame_forced_reg;
    logic                              clearing_reg;
    logic [dpg_pkg::STORE_AW-1:0]      clear_addr_reg;

    logic                              in_force;
    logic [dpg_pkg::X_W-1:0]           in_x;
    logic [dpg_pkg::Y_W-1:0]           in_y;
    logic [dpg_pkg::PIX_W-1:0]         in_value;
    logic [dpg_pkg::GAMMA_AW-1:0]      in_tindex;
    logic [dpg_pkg::LEVEL_W-1:0]       in_tvalue;
    logic                              accept;
    logic                              in_frame;

    assign in_force  = s_tdata[0];
    assign in_x      = s_tdata[7:1];
    assign in_y      = s_tdata[13:8];
    assign in_value  = s_tdata[29:14];
    assign in_tindex = s_tdata[37:30];
    assign in_tvalue = s_tdata[45:38];
    assign accept    = s_tvalid && s_tready;
    assign in_frame  = ({1'b0, in_x} < frame_width_reg) && ({1'b0, in_y} < frame_height_reg)
                       && (int'(in_x) < dpg_pkg::MAX_WIDTH) && (int'(in_y) < dpg_pkg::MAX_HEIGHT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            double_buffer_reg <= 1'b0;
            frame_width_reg   <= dpg_pkg::FRAME_WIDTH_RST;
            frame_height_reg  <= dpg_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                dpg_pkg::CFG_DOUBLE_BUFFER: double_buffer_reg <= cfg_wdata[0];
                dpg_pkg::CFG_FRAME_WIDTH:   frame_width_reg   <= cfg_wdata;
                dpg_pkg::CFG_FRAME_HEIGHT:  frame_height_reg  <= cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            repaint_pending_reg <= 1'b1;
            frame_forced_reg    <= 1'b0;
        end else if (accept) begin
            if (s_tuser == dpg_pkg::MODE_FRAME_START) begin
                frame_forced_reg    <= in_force || double_buffer_reg || repaint_pending_reg;
                repaint_pending_reg <= 1'b0;
            end else if (s_tuser == dpg_pkg::MODE_GAMMA_WRITE) begin
                repaint_pending_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clearing_reg   <= 1'b1;
            clear_addr_reg <= '0;
        end else if (clearing_reg) begin
            clear_addr_reg <= clear_addr_reg + 1'b1;
            if (clear_addr_reg == dpg_pkg::STORE_AW'(dpg_pkg::STORE_DEPTH - 1)) begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // stage 1: store read data valid, compare
    logic                              s1_valid_reg;
    logic                              s1_flip_reg;
    logic                              s1_forced_reg;
    logic [dpg_pkg::X_W-1:0]           s1_x_reg;
    logic [dpg_pkg::Y_W-1:0]           s1_y_reg;
    logic [dpg_pkg::PIX_W-1:0]         s1_value_reg;
    logic [dpg_pkg::STORE_AW-1:0]      s1_addr;
    logic [dpg_pkg::PIX_W-1:0]         store_rdata;
    logic [dpg_pkg::PIX_W-1:0]         prev_value;
    logic                              draw;

    logic                              fwd_valid_reg;
    logic [dpg_pkg::STORE_AW-1:0]      fwd_addr_reg;
    logic [dpg_pkg::PIX_W-1:0]         fwd_value_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= accept &&
                            (((s_tuser == dpg_pkg::MODE_PIXEL) && in_frame) ||
                             ((s_tuser == dpg_pkg::MODE_FRAME_END) && double_buffer_reg));
        end
    end

    always_ff @(posedge aclk) begin
        s1_flip_reg   <= (s_tuser == dpg_pkg::MODE_FRAME_END);
        s1_forced_reg <= frame_forced_reg;
        s1_x_reg      <= in_x;
        s1_y_reg      <= in_y;
        s1_value_reg  <= in_value;
    end

    assign s1_addr    = dpg_pkg::store_addr(s1_x_reg, s1_y_reg);
    assign prev_value = (fwd_valid_reg && (fwd_addr_reg == s1_addr)) ? fwd_value_reg
                                                                     : store_rdata;
    assign draw       = s1_valid_reg && !s1_flip_reg &&
                        (s1_forced_reg || (prev_value != s1_value_reg));

    // write-back just issued is not yet visible to the read of the next request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_valid_reg <= 1'b0;
        end else begin
            fwd_valid_reg <= draw;
        end
    end

    always_ff @(posedge aclk) begin
        fwd_addr_reg  <= s1_addr;
        fwd_value_reg <= s1_value_reg;
    end

    dpg_ram #(.DEPTH(dpg_pkg::STORE_DEPTH), .WIDTH(dpg_pkg::PIX_W)) u_store (
        .clk   (aclk),
        .we    (clearing_reg || draw),
        .waddr (clearing_reg ? clear_addr_reg : s1_addr),
        .wdata (clearing_reg ? '0 : s1_value_reg),
        .raddr (dpg_pkg::store_addr(in_x, in_y)),
        .rdata (store_rdata)
    );

    // stage 2: gamma data valid, push to queue
    logic                              s2_valid_reg;
    logic                              s2_flip_reg;
    logic [dpg_pkg::X_W-1:0]           s2_x_reg;
    logic [dpg_pkg::Y_W-1:0]           s2_y_reg;
    logic [dpg_pkg::LEVEL_W-1:0]       g_red;
    logic [dpg_pkg::LEVEL_W-1:0]       g_green;
    logic [dpg_pkg::LEVEL_W-1:0]       g_blue;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else begin
            s2_valid_reg <= s1_valid_reg && (s1_flip_reg || draw);
        end
    end

    always_ff @(posedge aclk) begin
        s2_flip_reg <= s1_flip_reg;
        s2_x_reg    <= s1_x_reg;
        s2_y_reg    <= s1_y_reg;
    end

    dpg_gamma u_gamma (
        .aclk     (aclk),
        .wr_en    (accept && (s_tuser == dpg_pkg::MODE_GAMMA_WRITE)),
        .wr_index (in_tindex),
        .wr_value (in_tvalue),
        .pixel    (s1_value_reg),
        .red      (g_red),
        .green    (g_green),
        .blue     (g_blue)
    );

    dpg_pkg::dpg_out_t                 push_data;
    dpg_pkg::dpg_out_t                 head;
    logic [dpg_pkg::FIFO_PTR_W:0]      fifo_count;
    logic [dpg_pkg::FIFO_PTR_W:0]      occupancy;

    always_comb begin
        if (s2_flip_reg) begin
            push_data      = '0;
            push_data.kind = dpg_pkg::KIND_FLIP;
        end else begin
            push_data.kind  = dpg_pkg::KIND_DRAW;
            push_data.x     = s2_x_reg;
            push_data.y     = s2_y_reg;
            push_data.red   = g_red;
            push_data.green = g_green;
            push_data.blue  = g_blue;
        end
    end

    dpg_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s2_valid_reg),
        .push_data (push_data),
        .pop       (m_tvalid && m_tready),
        .head      (head),
        .not_empty (m_tvalid),
        .count     (fifo_count)
    );

    assign occupancy = fifo_count + (dpg_pkg::FIFO_PTR_W + 1)'(s1_valid_reg)
                                  + (dpg_pkg::FIFO_PTR_W + 1)'(s2_valid_reg);
    assign s_tready  = !clearing_reg && (occupancy < (dpg_pkg::FIFO_PTR_W + 1)'(dpg_pkg::FIFO_DEPTH));

    assign m_tuser = head.kind;
    assign m_tdata = {3'b000, head.blue, head.green, head.red, head.y, head.x};

endmodule

`default_nettype wire

### hdl/dpg_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module dpg_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### hdl/dpg_gamma.sv
// Gamma lookup: RGB565 bit replication and three table copies, one per channel.
`timescale 1ns / 1ps
`default_nettype none

module dpg_gamma (
    input  wire logic                          aclk,
    input  wire logic                          wr_en,
    input  wire logic [dpg_pkg::GAMMA_AW-1:0]  wr_index,
    input  wire logic [dpg_pkg::LEVEL_W-1:0]   wr_value,
    input  wire logic [dpg_pkg::PIX_W-1:0]     pixel,
    output logic      [dpg_pkg::LEVEL_W-1:0]   red,
    output logic      [dpg_pkg::LEVEL_W-1:0]   green,
    output logic      [dpg_pkg::LEVEL_W-1:0]   blue
);

    logic [dpg_pkg::GAMMA_AW-1:0] red_idx;
    logic [dpg_pkg::GAMMA_AW-1:0] green_idx;
    logic [dpg_pkg::GAMMA_AW-1:0] blue_idx;

    assign red_idx   = dpg_pkg::widen5(pixel[15:11]);
    assign green_idx = dpg_pkg::widen6(pixel[10:5]);
    assign blue_idx  = dpg_pkg::widen5(pixel[4:0]);

    dpg_ram #(.DEPTH(dpg_pkg::GAMMA_DEPTH), .WIDTH(dpg_pkg::LEVEL_W)) u_red (
        .clk(aclk), .we(wr_en), .waddr(wr_index), .wdata(wr_value),
        .raddr(red_idx), .rdata(red)
    );

    dpg_ram #(.DEPTH(dpg_pkg::GAMMA_DEPTH), .WIDTH(dpg_pkg::LEVEL_W)) u_green (
        .clk(aclk), .we(wr_en), .waddr(wr_index), .wdata(wr_value),
        .raddr(green_idx), .rdata(green)
    );

    dpg_ram #(.DEPTH(dpg_pkg::GAMMA_DEPTH), .WIDTH(dpg_pkg::LEVEL_W)) u_blue (
        .clk(aclk), .we(wr_en), .waddr(wr_index), .wdata(wr_value),
        .raddr(blue_idx), .rdata(blue)
    );

endmodule

`default_nettype wire

### hdl/dpg_fifo.sv
// Small output queue that decouples the pipeline from the receiver.
`timescale 1ns / 1ps
`default_nettype none

module dpg_fifo (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          push,
    input  wire dpg_pkg::dpg_out_t             push_data,
    input  wire logic                          pop,
    output dpg_pkg::dpg_out_t                  head,
    output logic                               not_empty,
    output logic [dpg_pkg::FIFO_PTR_W:0]       count
);

    dpg_pkg::dpg_out_t                 slot_reg [dpg_pkg::FIFO_DEPTH];
    logic [dpg_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [dpg_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [dpg_pkg::FIFO_PTR_W:0]      count_reg;
    logic [dpg_pkg::FIFO_PTR_W:0]      count_next;

    assign head      = slot_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign count     = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (!push && pop) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### hdl/dpg_checker.sv
// Port-level checks for the dirty-pixel gamma presenter, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module dpg_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            s_tready,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [dpg_pkg::M_TDATA_W-1:0]   m_tdata,
    input wire logic                            m_tuser
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result request dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
        else $error("result payload changed while stalled");

    a_flip_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == dpg_pkg::KIND_FLIP) |-> (m_tdata == '0))
        else $error("flip request carries nonzero data");

    a_clear_blocks: assert property (@(posedge aclk)
        !aresetn |=> !s_tready)
        else $error("input ready during store clearing");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result present right after reset");

endmodule

bind dirty_pixel_gamma_presenter dpg_checker u_dpg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### test/dirty_pixel_gamma_presenter_test.sv
// Self-checking testbench for dirty_pixel_gamma_presenter: directed and random frame streams.
`timescale 1ns / 1ps

module dirty_pixel_gamma_presenter_test;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam logic [dpg_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]  mode;
        logic        force_req;
        logic [6:0]  x;
        logic [5:0]  y;
        logic [15:0] value;
        logic [7:0]  tindex;
        logic [7:0]  tvalue;
    } panel_req_t;

    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [dpg_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [dpg_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                           s_tvalid  = 1'b0;
    logic                           s_tready;
    logic [dpg_pkg::S_TDATA_W-1:0]  s_tdata   = '0;
    logic [1:0]                     s_tuser   = '0;
    logic                           m_tvalid;
    logic                           m_tready  = 1'b0;
    logic [dpg_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_tuser;

    // shadow state of the block
    logic [15:0] shadow_frame [0:dpg_pkg::STORE_DEPTH-1];
    logic [7:0]  shadow_gamma [0:dpg_pkg::GAMMA_DEPTH-1];
    logic        repaint_due  = 1'b1;
    logic        frame_forced = 1'b0;
    logic        db_sh        = 1'b0;
    logic [7:0]  width_sh     = dpg_pkg::FRAME_WIDTH_RST;
    logic [6:0]  height_sh    = dpg_pkg::FRAME_HEIGHT_RST;

    dpg_pkg::dpg_out_t due_updates [$];
    dpg_pkg::dpg_out_t want;
    int mismatch_count = 0;
    int src_gap_max    = 8;
    int sink_gap_max   = 8;
    int sink_hold      = 0;
    int sink_wait      = 0;

    dirty_pixel_gamma_presenter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("dirty_pixel_gamma_presenter test failed");
        $finish;
    end

    task automatic flag_mismatch(input string msg);
        if (mismatch_count < 100) $display("MISMATCH @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // expected result of one accepted request
    task automatic present_request(input panel_req_t r);
        dpg_pkg::dpg_out_t o;
        logic [4:0] r5;
        logic [5:0] g6;
        logic [4:0] b5;
        o = '0;
        r5 = r.value[15:11];
        g6 = r.value[10:5];
        b5 = r.value[4:0];
        case (r.mode)
            dpg_pkg::MODE_FRAME_START: begin
                frame_forced = r.force_req | db_sh | repaint_due;
                repaint_due = 1'b0;
            end
            dpg_pkg::MODE_GAMMA_WRITE: begin
                shadow_gamma[r.tindex] = r.tvalue;
                repaint_due = 1'b1;
            end
            dpg_pkg::MODE_FRAME_END: begin
                if (db_sh) begin
                    o.kind = dpg_pkg::KIND_FLIP;
                    due_updates.push_back(o);
                end
            end
            dpg_pkg::MODE_PIXEL: begin
                if (r.x < width_sh && r.y < height_sh &&
                    (frame_forced || shadow_frame[{r.y, r.x}] != r.value)) begin
                    shadow_frame[{r.y, r.x}] = r.value;
                    o.kind  = dpg_pkg::KIND_DRAW;
                    o.x     = r.x;
                    o.y     = r.y;
                    o.red   = shadow_gamma[{r5, r5[4:2]}];
                    o.green = shadow_gamma[{g6, g6[5:4]}];
                    o.blue  = shadow_gamma[{b5, b5[4:2]}];
                    due_updates.push_back(o);
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_request(input panel_req_t r);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= r.mode;
        s_tdata  <= {2'b00, r.tvalue, r.tindex, r.value, r.y, r.x, r.force_req};
        do @(posedge aclk); while (!s_tready);
        present_request(r);
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    function automatic panel_req_t random_fill();
        panel_req_t r;
        r.mode      = 2'($urandom_range(0, 3));
        r.force_req = 1'($urandom);
        r.x         = 7'($urandom);
        r.y         = 6'($urandom);
        r.value     = 16'($urandom);
        r.tindex    = 8'($urandom);
        r.tvalue    = 8'($urandom);
        return r;
    endfunction

    task automatic send_pixel(input logic [6:0] x, input logic [5:0] y, input logic [15:0] v);
        panel_req_t r;
        r = random_fill();
        r.mode  = dpg_pkg::MODE_PIXEL;
        r.x     = x;
        r.y     = y;
        r.value = v;
        send_request(r);
    endtask

    task automatic send_frame_start(input logic force_req);
        panel_req_t r;
        r = random_fill();
        r.mode      = dpg_pkg::MODE_FRAME_START;
        r.force_req = force_req;
        send_request(r);
    endtask

    task automatic send_frame_end();
        panel_req_t r;
        r = random_fill();
        r.mode = dpg_pkg::MODE_FRAME_END;
        send_request(r);
    endtask

    task automatic send_gamma(input logic [7:0] idx, input logic [7:0] val);
        panel_req_t r;
        r = random_fill();
        r.mode   = dpg_pkg::MODE_GAMMA_WRITE;
        r.tindex = idx;
        r.tvalue = val;
        send_request(r);
    endtask

    task automatic send_random_pixel();
        int xlim;
        int ylim;
        logic [6:0] x;
        logic [5:0] y;
        logic [15:0] v;
        xlim = (width_sh == 0 || width_sh > 128) ? 127 : width_sh - 1;
        ylim = (height_sh == 0 || height_sh > 64) ? 63 : height_sh - 1;
        if ($urandom_range(0, 9) == 0) begin
            x = 7'($urandom);
            y = 6'($urandom);
        end else begin
            x = 7'($urandom_range(0, xlim));
            y = 6'($urandom_range(0, ylim));
        end
        case ($urandom_range(0, 5))
            0, 1: v = shadow_frame[{y, x}];
            2: v = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: v = 16'($urandom);
        endcase
        send_pixel(x, y, v);
    endtask

    // stop sending, let every result out, then let dropped requests clear the pipe
    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (due_updates.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_setting(input logic [dpg_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [7:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            dpg_pkg::CFG_DOUBLE_BUFFER: db_sh = val[0];
            dpg_pkg::CFG_FRAME_WIDTH:   width_sh = val;
            dpg_pkg::CFG_FRAME_HEIGHT:  height_sh = val[6:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_setting(input logic db, input logic [7:0] w, input logic [6:0] h);
        drain_and_settle();
        write_setting(dpg_pkg::CFG_DOUBLE_BUFFER, {7'd0, db});
        write_setting(dpg_pkg::CFG_FRAME_WIDTH, w);
        write_setting(dpg_pkg::CFG_FRAME_HEIGHT, {1'b0, h});
    endtask

    task automatic test_gamma_load();
        for (int i = 0; i < dpg_pkg::GAMMA_DEPTH; i++) begin
            if (i == 0) send_gamma(8'(i), 8'hFF);
            else if (i == dpg_pkg::GAMMA_DEPTH - 1) send_gamma(8'(i), 8'h00);
            else send_gamma(8'(i), 8'($urandom));
        end
    endtask

    // store is zero and no frame has started: only changed pixels show up
    task automatic test_pixels_before_frame_start();
        send_pixel(7'd0, 6'd0, 16'h0000);
        send_pixel(7'd127, 6'd63, 16'hFFFF);
        send_pixel(7'd127, 6'd63, 16'hFFFF);
        send_pixel(7'd64, 6'd32, 16'h8421);
    endtask

    task automatic test_frame_forcing();
        send_frame_start(1'b0);
        send_pixel(7'd127, 6'd63, 16'hFFFF);
        send_frame_end();
        send_frame_start(1'b0);
        send_pixel(7'd127, 6'd63, 16'hFFFF);
        send_pixel(7'd1, 6'd1, 16'hF800);
        send_pixel(7'd2, 6'd1, 16'h07E0);
        send_pixel(7'd3, 6'd1, 16'h001F);
        send_frame_start(1'b1);
        send_pixel(7'd1, 6'd1, 16'hF800);
        send_gamma(8'h00, 8'h01);
        send_frame_start(1'b0);
        send_pixel(7'd2, 6'd1, 16'h07E0);
        send_frame_end();
    endtask

    task automatic test_frame_bounds();
        apply_setting(1'b0, 8'd1, 7'd1);
        send_frame_start(1'b0);
        send_pixel(7'd1, 6'd0, 16'h1111);
        send_pixel(7'd0, 6'd1, 16'h2222);
        send_pixel(7'd0, 6'd0, 16'h1234);
        apply_setting(1'b0, 8'd0, 7'd64);
        send_pixel(7'd0, 6'd0, 16'h5555);
        apply_setting(1'b0, 8'd128, 7'd64);
        write_setting(CFG_UNUSED, 8'hFF);
        send_pixel(7'd127, 6'd63, 16'h0000);
        send_frame_end();
    endtask

    task automatic test_double_buffer_flip();
        apply_setting(1'b1, 8'd128, 7'd64);
        send_frame_start(1'b0);
        send_pixel(7'd127, 6'd63, 16'h0000);
        send_frame_end();
        apply_setting(1'b0, 8'd128, 7'd64);
        send_frame_end();
    endtask

    task automatic run_phase(input logic db, input logic [7:0] w, input logic [6:0] h,
                             input int src_gap, input int sink_gap, input int n_requests);
        int sent;
        int npix;
        int pick;
        sent = 0;
        apply_setting(db, w, h);
        src_gap_max  = src_gap;
        sink_gap_max = sink_gap;
        while (sent < n_requests) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) begin
                send_request(random_fill());
                sent++;
            end else if (pick == 1) begin
                send_gamma(8'($urandom), 8'($urandom));
                sent++;
            end else begin
                npix = $urandom_range(1, 24);
                send_frame_start($urandom_range(0, 3) == 0);
                repeat (npix) send_random_pixel();
                send_frame_end();
                sent += npix + 2;
            end
        end
    endtask

    task automatic test_random_frames();
        run_phase(1'b0, 8'd128, 7'd64, 8, 8, 90);
        run_phase(1'b1, 8'd1, 7'd1, 0, 0, 90);
        run_phase(1'b0, 8'd8, 7'd4, 8, 0, 90);
        run_phase(1'b1, 8'd128, 7'd64, 0, 8, 90);
        run_phase(1'b0, 8'd0, 7'd64, 3, 3, 40);
        run_phase(1'b0, 8'd255, 7'd127, 8, 8, 90);
        run_phase(1'b0, 8'd37, 7'd13, 0, 0, 90);
        run_phase(1'($urandom), 8'($urandom_range(1, 128)), 7'($urandom_range(1, 64)),
                  8, 8, 90);
    endtask

    // result side holds off while requests keep coming, so the input must stall
    task automatic test_output_backpressure();
        apply_setting(1'b0, 8'd128, 7'd64);
        src_gap_max = 0;
        sink_hold = HOLD_CYCLES;
        send_frame_start(1'b1);
        repeat (40) send_random_pixel();
        send_frame_end();
        drain_and_settle();
    endtask

    // result sink
    initial begin
        forever begin
            @(posedge aclk);
            if (sink_hold > 0) begin
                sink_hold--;
                m_tready <= 1'b0;
            end else if (sink_wait > 0) begin
                sink_wait--;
                m_tready <= (sink_wait == 0);
            end else if (m_tvalid && m_tready) begin
                sink_wait = $urandom_range(0, sink_gap_max);
                m_tready <= (sink_wait == 0);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (due_updates.size() == 0) begin
                flag_mismatch("result with nothing expected");
            end else begin
                want = due_updates.pop_front();
                if (m_tuser !== want.kind)
                    flag_mismatch($sformatf("kind %0h, want %0h", m_tuser, want.kind));
                if (m_tdata[6:0] !== want.x)
                    flag_mismatch($sformatf("x %0h, want %0h", m_tdata[6:0], want.x));
                if (m_tdata[12:7] !== want.y)
                    flag_mismatch($sformatf("y %0h, want %0h", m_tdata[12:7], want.y));
                if (m_tdata[20:13] !== want.red)
                    flag_mismatch($sformatf("red %0h, want %0h", m_tdata[20:13], want.red));
                if (m_tdata[28:21] !== want.green)
                    flag_mismatch($sformatf("green %0h, want %0h", m_tdata[28:21], want.green));
                if (m_tdata[36:29] !== want.blue)
                    flag_mismatch($sformatf("blue %0h, want %0h", m_tdata[36:29], want.blue));
            end
        end
    end

    initial begin
        foreach (shadow_frame[i]) shadow_frame[i] = '0;
        foreach (shadow_gamma[i]) shadow_gamma[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_gamma_load();
        test_pixels_before_frame_start();
        test_frame_forcing();
        test_frame_bounds();
        test_double_buffer_flip();
        test_random_frames();
        test_output_backpressure();
        drain_and_settle();
        repeat (16) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("dirty_pixel_gamma_presenter test passed");
        end else begin
            $display("dirty_pixel_gamma_presenter test failed");
        end
        $finish;
    end

endmodule
